// ----- rtl/bba_pkg.sv -----
package bba_pkg;

  // Fixed field widths of the request, result and register words.
  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 17;
  localparam int COUNT_W   = 9;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  // The used map is stored as rows of ROW_W bits.
  localparam int ROW_W     = 32;
  localparam int ROW_BIT_W = 5;

  localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RESET = '0;
  localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RESET   = 17'd16;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET  = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_NOT_USED = 2'd3
  } status_t;

  typedef struct packed {
    op_t               operation;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] block_address;
    status_t           status;
    logic              all_free;
  } rsp_t;

endpackage

// ----- rtl/bba_divider.sv -----
module bba_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bba_pkg::ADDR_W-1:0]   dividend,
  input  logic [bba_pkg::SIZE_W-1:0]   divisor,
  output logic                         done,
  output logic [bba_pkg::ADDR_W-1:0]   quotient,
  output logic [bba_pkg::SIZE_W-1:0]   remainder
);
  import bba_pkg::*;

  localparam int STEP_W = $clog2(ADDR_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [SIZE_W:0]   shifted;
  logic              fits;

  // Restoring division, one quotient bit per cycle, most significant first.
  always_comb begin
    shifted = {remainder, quotient[ADDR_W-1]};
    fits    = (shifted >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        step      <= '0;
        quotient  <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (fits) begin
          remainder <= SIZE_W'(shifted - {1'b0, divisor});
        end else begin
          remainder <= shifted[SIZE_W-1:0];
        end
        quotient <= {quotient[ADDR_W-2:0], fits};
        step     <= step + 1'b1;
        if (step == STEP_W'(ADDR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/bba_bitmap.sv -----
module bba_bitmap #(
  parameter int ROWS   = 8,
  parameter int ROW_AW = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [ROW_AW-1:0]          rd_row,
  output logic [bba_pkg::ROW_W-1:0]  rd_data,
  input  logic                       wr_en,
  input  logic [ROW_AW-1:0]          wr_row,
  input  logic [bba_pkg::ROW_W-1:0]  wr_data
);
  import bba_pkg::*;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROWS-1:0]  row_valid;

  // A row that was never written since reset reads as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= row_valid[rd_row] ? mem[rd_row] : '0;
    end
  end

endmodule

// ----- rtl/bitmap_block_allocator.sv -----
// An allocate reads and checks one 32-block row at a time, then forms the address by a
// multiply and an add; a free runs the bit-serial divider (one bit a cycle) first.
// Throughput: one word at a time; the next word is taken once the result is in the output
// register, so a result waiting on rsp_stall does not hold up the next request.
// Reset (rst, synchronous, active high) restores the register defaults and marks every
// block free at once through per-row valid bits; no clearing pass is needed.
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  bba_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output bba_pkg::rsp_t                 rsp
);
  import bba_pkg::*;

  // The map is organized as rows of ROW_W bits; a block index is {row, bit}.
  localparam int ROWS    = (MAX_BLOCKS + ROW_W - 1) / ROW_W;
  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W   = ROW_AW + ROW_BIT_W;
  localparam int CMP_W   = IDX_W + 1;
  localparam int CLAMP_W = (CMP_W > COUNT_W) ? CMP_W : COUNT_W;
  localparam int PROD_W  = IDX_W + SIZE_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MUL,
    S_ADD,
    S_DIV,
    S_FREE_RD,
    S_FREE_CHK,
    S_RESULT
  } state_t;

  // Configuration registers.
  logic [ADDR_W-1:0]  base_address;
  logic [SIZE_W-1:0]  block_size;
  logic [COUNT_W-1:0] block_count;

  // Sequencer state and working registers.
  state_t            state;
  logic [ROW_AW-1:0] scan_row;
  logic [IDX_W-1:0]  idx;
  logic [PROD_W-1:0] product;
  logic [ADDR_W-1:0] blk_addr;
  status_t           status;
  logic [CMP_W-1:0]  used_count;

  // Derived values.
  logic [SIZE_W-1:0]  eff_size;
  logic [CLAMP_W-1:0] count_wide;
  logic [CMP_W-1:0]   eff_count;
  logic               accept;

  // Row scan.
  logic [ROW_W-1:0]     rd_data;
  logic [ROW_W-1:0]     free_bits;
  logic                 found;
  logic [ROW_BIT_W-1:0] pos;
  logic [CMP_W-1:0]     next_row_base;
  logic                 last_row;

  // Free check.
  logic [ROW_AW-1:0]    idx_row;
  logic [ROW_BIT_W-1:0] idx_bit;

  // Bitmap and divider controls.
  logic              map_rd_en;
  logic [ROW_AW-1:0] map_rd_row;
  logic              map_wr_en;
  logic [ROW_AW-1:0] map_wr_row;
  logic [ROW_W-1:0]  map_wr_data;
  logic              div_start;
  logic              div_done;
  logic [ADDR_W-1:0] div_quot;
  logic [SIZE_W-1:0] div_rem;

  // A block size of zero behaves as one byte; the block count saturates at capacity.
  always_comb begin
    eff_size   = (block_size == '0) ? SIZE_W'(1) : block_size;
    count_wide = (CLAMP_W'(block_count) > CLAMP_W'(MAX_BLOCKS)) ?
                 CLAMP_W'(MAX_BLOCKS) : CLAMP_W'(block_count);
    eff_count  = CMP_W'(count_wide);
  end

  // The block only takes a request word while the sequencer is idle.
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // Free bits of the row just read, limited to blocks below the block count. The lowest
  // free one wins.
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int j = 0; j < ROW_W; j++) begin
      free_bits[j] = !rd_data[j] && (CMP_W'({scan_row, ROW_BIT_W'(j)}) < eff_count);
    end
    for (int j = ROW_W - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        found = 1'b1;
        pos   = ROW_BIT_W'(j);
      end
    end
    next_row_base = CMP_W'({scan_row, ROW_BIT_W'(0)}) + CMP_W'(ROW_W);
    last_row      = (next_row_base >= eff_count);
  end

  assign idx_row = idx[IDX_W-1:ROW_BIT_W];
  assign idx_bit = idx[ROW_BIT_W-1:0];

  // Map accesses: one read per row visited, a read-modify-write when a bit changes.
  always_comb begin
    map_rd_en   = (state == S_SCAN_RD) || (state == S_FREE_RD);
    map_rd_row  = (state == S_SCAN_RD) ? scan_row : idx_row;
    map_wr_en   = ((state == S_SCAN_CHK) && found) ||
                  ((state == S_FREE_CHK) && rd_data[idx_bit]);
    map_wr_row  = (state == S_SCAN_CHK) ? scan_row : idx_row;
    map_wr_data = (state == S_SCAN_CHK) ?
                  (rd_data | (ROW_W'(1) << pos)) :
                  (rd_data & ~(ROW_W'(1) << idx_bit));
  end

  // The divider runs only for a free whose address is at or above the pool base.
  assign div_start = accept && (req.operation == OP_FREE) && (req.address >= base_address);

  bba_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (req.address - base_address),
    .divisor   (eff_size),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  bba_bitmap #(
    .ROWS   (ROWS),
    .ROW_AW (ROW_AW)
  ) u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (map_rd_en),
    .rd_row  (map_rd_row),
    .rd_data (rd_data),
    .wr_en   (map_wr_en),
    .wr_row  (map_wr_row),
    .wr_data (map_wr_data)
  );

  // Register writes never touch the used map.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_ADDRESS_RESET;
      block_size   <= BLOCK_SIZE_RESET;
      block_count  <= BLOCK_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE:  base_address <= cfg_data[ADDR_W-1:0];
        REG_SIZE:  block_size   <= cfg_data[SIZE_W-1:0];
        REG_COUNT: block_count  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The sequencer. used_count tracks every set bit of the map, including bits left above a
  // lowered block count, so the all-free flag needs no sweep of the map.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      rsp_valid  <= 1'b0;
      scan_row   <= '0;
      status     <= ST_DONE;
    end else begin
      // A word taken from the output register empties it, unless a new result
      // is loaded in the same cycle.
      if (rsp_valid && !rsp_stall && (state != S_RESULT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            blk_addr <= '0;
            scan_row <= '0;
            if (req.operation == OP_ALLOC) begin
              if (eff_count == '0) begin
                status <= ST_FULL;
                state  <= S_RESULT;
              end else begin
                status <= ST_DONE;
                state  <= S_SCAN_RD;
              end
            end else if (req.address < base_address) begin
              status <= ST_BAD_ADDR;
              state  <= S_RESULT;
            end else begin
              status <= ST_DONE;
              state  <= S_DIV;
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (found) begin
            idx        <= {scan_row, pos};
            used_count <= used_count + 1'b1;
            state      <= S_MUL;
          end else if (last_row) begin
            status <= ST_FULL;
            state  <= S_RESULT;
          end else begin
            scan_row <= scan_row + 1'b1;
            state    <= S_SCAN_RD;
          end
        end
        S_MUL: begin
          product <= PROD_W'(idx) * PROD_W'(eff_size);
          state   <= S_ADD;
        end
        S_ADD: begin
          // The block address wraps modulo 2^32.
          blk_addr <= base_address + ADDR_W'(product);
          state    <= S_RESULT;
        end
        S_DIV: begin
          if (div_done) begin
            // Outside the pool or off a block boundary.
            if ((div_rem != '0) || (div_quot >= ADDR_W'(eff_count))) begin
              status <= ST_BAD_ADDR;
              state  <= S_RESULT;
            end else begin
              idx   <= div_quot[IDX_W-1:0];
              state <= S_FREE_RD;
            end
          end
        end
        S_FREE_RD: begin
          state <= S_FREE_CHK;
        end
        S_FREE_CHK: begin
          if (rd_data[idx_bit]) begin
            used_count <= used_count - 1'b1;
            status     <= ST_DONE;
          end else begin
            status <= ST_NOT_USED;
          end
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.block_address <= blk_addr;
            rsp.status        <= status;
            rsp.all_free      <= (used_count == '0);
            rsp_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- verif/bitmap_block_allocator_test.sv -----
module bitmap_block_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  // Built capacity of the allocator under test.
  localparam int POOL_CAPACITY = 256;

  // Random traffic is run as four idling phases, each of which visits a few
  // pool settings with a fresh batch of requests.
  localparam int POOLS_PER_PHASE = 4;
  localparam int ITEMS_PER_POOL  = 100;

  // Quiet cycles that let the block settle; this is longer than a free or
  // the longest allocate takes.
  localparam int SETTLE_CYCLES = 50;

  // Length of the receiver hold-off in the backpressure test.
  localparam int HOLD_CYCLES = 300;

  // The slowest legal run stays far below this many cycles.
  localparam int CYCLE_LIMIT = 1000000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BASE;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;

  // Percentages of cycles in which the request side stays idle and the
  // response side stalls. The test tasks change them from phase to phase.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  // Set for a long stretch by the backpressure test to hold off every response.
  logic hold_off = 1'b0;

  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Our own view of the allocator: the three pool registers and one used bit
  // per block. Register writes leave the used bits alone.
  logic [ADDR_W-1:0]        pool_base  = BASE_ADDRESS_RESET;
  logic [SIZE_W-1:0]        pool_size  = BLOCK_SIZE_RESET;
  logic [COUNT_W-1:0]       pool_count = BLOCK_COUNT_RESET;
  logic [POOL_CAPACITY-1:0] pool_used  = '0;

  // Responses owed by the block, oldest first.
  rsp_t owed_responses[$];

  bitmap_block_allocator #(
    .MAX_BLOCKS(POOL_CAPACITY)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // A zero block size behaves as one byte, and a block count above the built
  // capacity saturates to it.
  function automatic longint unsigned active_size();
    return (pool_size == '0) ? 64'd1 : 64'(pool_size);
  endfunction

  function automatic int unsigned active_count();
    return (pool_count > POOL_CAPACITY) ? POOL_CAPACITY : int'(pool_count);
  endfunction

  // Works out the response to one request and applies it to the used map.
  // The pool span is computed in 64 bits so that a pool reaching past the top
  // of the address space is judged correctly, while an allocated address wraps
  // modulo 2^32 like the hardware adder.
  function automatic rsp_t serve_request(req_t word);
    rsp_t              answer;
    longint unsigned   sz;
    longint unsigned   span;
    longint unsigned   offset;
    longint unsigned   idx;
    logic [63:0]       blk;
    int unsigned       cnt;
    int unsigned       i;
    bit                found;
    sz = active_size();
    cnt = active_count();
    answer = '0;
    answer.status = ST_DONE;
    if (word.operation == OP_ALLOC) begin
      found = 1'b0;
      idx = 0;
      // The lowest free block inside the active count wins.
      for (i = 0; i < cnt; i++) begin
        if (!found && !pool_used[i]) begin
          found = 1'b1;
          idx = i;
        end
      end
      if (found) begin
        pool_used[idx] = 1'b1;
        blk = 64'(pool_base) + idx * sz;
        answer.block_address = blk[ADDR_W-1:0];
      end else begin
        answer.status = ST_FULL;
      end
    end else begin
      // An address below the base is never part of the pool, which also
      // covers blocks whose address wrapped around zero.
      if (word.address < pool_base) begin
        answer.status = ST_BAD_ADDR;
      end else begin
        offset = 64'(word.address - pool_base);
        span = sz * cnt;
        if (offset >= span || (offset % sz) != 0) begin
          answer.status = ST_BAD_ADDR;
        end else begin
          idx = offset / sz;
          if (idx >= POOL_CAPACITY || !pool_used[idx]) begin
            answer.status = ST_NOT_USED;
          end else begin
            pool_used[idx] = 1'b0;
          end
        end
      end
    end
    // Bits beyond a lowered block count still count here.
    answer.all_free = (pool_used == '0);
    return answer;
  endfunction

  // Picks the address for a free request. Most of the time it names a block
  // that is in use, so that frees actually succeed; the rest are misaligned,
  // below-base, just-past-the-end or fully random addresses.
  function automatic logic [ADDR_W-1:0] choose_free_address();
    longint unsigned sz;
    int unsigned     cnt;
    int unsigned     idx;
    int unsigned     k;
    bit              found;
    logic [63:0]     blk;
    logic [ADDR_W-1:0] addr;
    sz = active_size();
    cnt = active_count();
    idx = (cnt == 0) ? 0 : $urandom_range(cnt - 1);
    found = 1'b0;
    for (k = 0; k < cnt; k++) begin
      if (!found && pool_used[(idx + k) % cnt]) begin
        found = 1'b1;
        idx = (idx + k) % cnt;
      end
    end
    blk = 64'(pool_base) + idx * sz;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: addr = blk[ADDR_W-1:0];
      6: addr = blk[ADDR_W-1:0] + ((sz > 1) ? $urandom_range(int'(sz) - 1, 1) : 1);
      7: addr = $urandom;
      8: addr = pool_base - 1 - $urandom_range(3);
      default: begin
        blk = 64'(pool_base) + cnt * sz;
        addr = blk[ADDR_W-1:0];
      end
    endcase
    return addr;
  endfunction

  // Sends one request word, idling at random before it, and records the
  // response it is owed once the block takes it. Valid stays high after the
  // word is taken; the next call or wait_idle decides when it drops.
  task automatic issue_request(op_t op, logic [ADDR_W-1:0] addr);
    req_t word;
    word.operation = op;
    word.address = addr;
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= word;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    owed_responses.push_back(serve_request(word));
  endtask

  // Drops valid and waits until every owed response is back, then lets the
  // block settle so that register writes land on an idle block.
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (owed_responses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register. The caller lowers the write enable afterwards, so
  // that back-to-back writes keep it high without a glitch.
  task automatic write_register(cfg_reg_t which, logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(posedge clk);
    case (which)
      REG_BASE:  pool_base = value;
      REG_SIZE:  pool_size = value[SIZE_W-1:0];
      REG_COUNT: pool_count = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_pool(logic [CFG_W-1:0] base, logic [CFG_W-1:0] size_word,
                          logic [CFG_W-1:0] count_word);
    wait_idle();
    write_register(REG_BASE, base);
    write_register(REG_SIZE, size_word);
    write_register(REG_COUNT, count_word);
    cfg_write <= 1'b0;
  endtask

  // Draws a random pool setting. The extremes come up often: zero and maximal
  // sizes, sizes above the documented range, an empty pool, a single block, a
  // full-capacity pool and counts that saturate. Small counts dominate so the
  // pool regularly fills. Upper data bits are sometimes junk, which the
  // registers must drop.
  task automatic choose_pool();
    logic [CFG_W-1:0] base;
    logic [CFG_W-1:0] size_word;
    logic [CFG_W-1:0] count_word;
    case ($urandom_range(3))
      0: base = '0;
      1: base = 32'hFFFF_FFFF - $urandom_range(255);
      default: base = $urandom;
    endcase
    case ($urandom_range(7))
      0: size_word = 0;
      1: size_word = 1;
      2: size_word = 65536;
      3: size_word = 131071;
      4: size_word = 1 << $urandom_range(16);
      5: size_word = $urandom_range(64, 1);
      default: size_word = $urandom_range(131071);
    endcase
    case ($urandom_range(7))
      0: count_word = 0;
      1: count_word = 1;
      2: count_word = POOL_CAPACITY;
      3: count_word = $urandom_range(511, POOL_CAPACITY + 1);
      default: count_word = $urandom_range(16, 2);
    endcase
    if ($urandom_range(3) == 0) size_word = size_word | ($urandom << SIZE_W);
    if ($urandom_range(3) == 0) count_word = count_word | ($urandom << COUNT_W);
    set_pool(base, size_word, count_word);
  endtask

  // Default registers straight out of reset: an empty map, two allocations,
  // a misaligned free, a good free, a double free, a free one past the end of
  // the pool, a free at the top of the address space and a final free that
  // leaves the map clear.
  task automatic test_basic_requests();
    issue_request(OP_FREE, 32'h0000_0000);
    issue_request(OP_ALLOC, $urandom);
    issue_request(OP_ALLOC, $urandom);
    issue_request(OP_FREE, 32'h0000_0008);
    issue_request(OP_FREE, 32'h0000_0010);
    issue_request(OP_FREE, 32'h0000_0010);
    issue_request(OP_FREE, 32'h0000_1000);
    issue_request(OP_FREE, 32'hFFFF_FFFF);
    issue_request(OP_FREE, 32'h0000_0000);
  endtask

  // Corner settings of the registers.
  task automatic test_register_corners();
    // An empty pool: allocations report full, frees a bad address.
    set_pool(32'h0, 32'd16, 32'd0);
    issue_request(OP_ALLOC, $urandom);
    issue_request(OP_FREE, 32'h0);
    // A zero block size acts as one byte; one block fills at once.
    set_pool(32'd100, 32'd0, 32'd1);
    issue_request(OP_ALLOC, $urandom);
    issue_request(OP_ALLOC, $urandom);
    issue_request(OP_FREE, 32'd101);
    issue_request(OP_FREE, 32'd100);
    // A pool just under the top of the address space: the third and fourth
    // blocks wrap to low addresses, and freeing a wrapped one is refused.
    set_pool(32'hFFFF_FFF0, 32'd8, 32'd4);
    repeat (4) issue_request(OP_ALLOC, $urandom);
    issue_request(OP_FREE, 32'h0);
    // Lowering the count strands the second block: it cannot be freed now.
    set_pool(32'hFFFF_FFF0, 32'd8, 32'd1);
    issue_request(OP_FREE, 32'hFFFF_FFF8);
    // A size above the documented range and a saturating count.
    set_pool(32'h0, 32'd131071, 32'd511);
    issue_request(OP_ALLOC, $urandom);
    issue_request(OP_FREE, 32'd131071);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering words back to back, so the block fills and stalls its input.
  task automatic test_backpressure();
    int unsigned n;
    idle_pct = 0;
    stall_pct = 0;
    set_pool(32'h0000_4000, 32'd32, 32'd8);
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    for (n = 0; n < 16; n++) begin
      if (n % 3 == 2) issue_request(OP_FREE, choose_free_address());
      else issue_request(OP_ALLOC, $urandom);
    end
    wait_idle();
  endtask

  // Random traffic with the given idling on both sides, over several pool
  // settings. The used map carries over from one setting to the next, which
  // exercises blocks stranded by a lowered count.
  task automatic test_random_traffic(int unsigned gap, int unsigned stall);
    int unsigned p;
    int unsigned n;
    int unsigned alloc_pct;
    idle_pct = gap;
    stall_pct = stall;
    for (p = 0; p < POOLS_PER_PHASE; p++) begin
      choose_pool();
      alloc_pct = $urandom_range(70, 35);
      for (n = 0; n < ITEMS_PER_POOL; n++) begin
        if ($urandom_range(99) < alloc_pct) issue_request(OP_ALLOC, $urandom);
        else issue_request(OP_FREE, choose_free_address());
      end
    end
    wait_idle();
  endtask

  // Response side: each word taken from the block is checked against the
  // oldest owed response, then the stall for the next cycle is decided. Both
  // the check and the stall use the values that stood at this clock edge.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_responses.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: response word with none owed: addr %h status %0d all_free %b",
                     $realtime, rsp.block_address, rsp.status, rsp.all_free);
          mismatches++;
        end else begin
          if (rsp.block_address !== owed_responses[0].block_address ||
              rsp.status !== owed_responses[0].status ||
              rsp.all_free !== owed_responses[0].all_free) begin
            if (mismatches < 10)
              $display("%0t: expected addr %h status %0d all_free %b, got addr %h status %0d all_free %b",
                       $realtime, owed_responses[0].block_address, owed_responses[0].status,
                       owed_responses[0].all_free, rsp.block_address, rsp.status,
                       rsp.all_free);
            mismatches++;
          end
          void'(owed_responses.pop_front());
        end
      end
      rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_basic_requests();
    test_register_corners();
    test_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(88, 0);
    test_random_traffic(0, 88);
    test_random_traffic(30, 30);
    wait_idle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
